### rtl/core/cafilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cafilt_pkg
// Shared types, constants and the arctangent table of the attitude filter.
// ----------------------------------------------------------------------------
package cafilt_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ANGLE_WIDTH       = 24;
   localparam int SQ_WIDTH          = 32;
   localparam int ROOT_WIDTH        = 24;
   localparam int ACC_WIDTH         = 18;
   localparam int ATAN_WIDTH        = 22;

   localparam logic [15:0] TIME_STEP_RESET   = 16'd66;
   localparam logic [15:0] BLEND_ALPHA_RESET = 16'd64684;

   localparam logic REG_TIME_STEP   = 1'b0;
   localparam logic REG_BLEND_ALPHA = 1'b1;

   typedef struct packed {
      logic signed [15:0] gyro_rate_x;
      logic signed [15:0] gyro_rate_y;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_data_type;

   typedef struct packed {
      logic signed [23:0] pitch_angle;
      logic signed [23:0] roll_angle;
   } rsp_data_type;

   // atan(2^-i) in degrees scaled by 65536
   function automatic logic [ATAN_WIDTH-1:0] atan_deg16(input logic [4:0] idx);
      logic [ATAN_WIDTH-1:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/core/cafilt_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cafilt_isqrt
// Digit-serial integer square root of sq*65536, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cafilt_isqrt (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [cafilt_pkg::SQ_WIDTH-1:0]     sq,
   output logic                                     done,
   output logic [cafilt_pkg::ROOT_WIDTH-1:0]        root
);
   localparam int RW = cafilt_pkg::ROOT_WIDTH;
   localparam int VW = 2 * RW;
   localparam int CW = $clog2(RW);

   logic          busy_ff, done_ff;
   logic [CW-1:0] cnt_ff;
   logic [VW-1:0] v_ff;
   logic [RW+1:0] rem_ff;
   logic [RW-1:0] root_ff;

   logic [RW+2:0] rem2;
   logic [RW+2:0] trial;
   logic          take;

   assign rem2  = {rem_ff[RW:0], v_ff[VW-1:VW-2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign take  = rem2 >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(RW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff    <= {sq, 16'h0000};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         v_ff <= {v_ff[VW-3:0], 2'b00};
         if (take) begin
            rem_ff  <= (RW+2)'(rem2 - trial);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= (RW+2)'(rem2);
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

### rtl/core/cafilt_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cafilt_cordic
// Vectoring CORDIC: atan2(num, root) in degrees scaled by 256, one
// iteration per cycle.
// ----------------------------------------------------------------------------
module cafilt_cordic #(
   parameter int ITERATIONS = cafilt_pkg::CORDIC_ITERATIONS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [cafilt_pkg::ROOT_WIDTH-1:0]       root,
   input  wire logic signed [15:0]                      num,
   output logic                                         done,
   output logic signed [cafilt_pkg::ACC_WIDTH-1:0]      angle
);
   localparam int XW = cafilt_pkg::ROOT_WIDTH + 4;
   localparam int ZW = cafilt_pkg::ACC_WIDTH + 8;
   localparam int CW = $clog2(ITERATIONS + 1);

   logic                 busy_ff, rnd_ff, done_ff;
   logic [CW-1:0]        cnt_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic signed [cafilt_pkg::ACC_WIDTH-1:0] angle_ff;

   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] step, zr;

   assign xs   = x_ff >>> cnt_ff;
   assign ys   = y_ff >>> cnt_ff;
   assign step = signed'(ZW'(cafilt_pkg::atan_deg16(5'(cnt_ff))));
   assign zr   = z_ff + ZW'(128);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         rnd_ff  <= 1'b0;
         done_ff <= rnd_ff;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(ITERATIONS - 1)) begin
               busy_ff <= 1'b0;
               rnd_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= signed'(XW'(root));
         y_ff <= XW'(num) <<< 8;
         z_ff <= '0;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + step;
         end else if (y_ff < 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - step;
         end
      end
      if (rnd_ff) begin
         angle_ff <= zr[ZW-1:8];
      end
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule
`default_nettype wire

### rtl/core/cafilt_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cafilt_blend
// Complementary blend of one axis: gyro increment, then a bit-serial
// alpha multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module cafilt_blend #(
   parameter int ANGLE_WIDTH = cafilt_pkg::ANGLE_WIDTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic signed [ANGLE_WIDTH-1:0]           old_angle,
   input  wire logic signed [15:0]                      rate,
   input  wire logic signed [cafilt_pkg::ACC_WIDTH-1:0] acc_angle,
   input  wire logic [15:0]                             time_step,
   input  wire logic [15:0]                             blend_alpha,
   output logic                                         done,
   output logic signed [ANGLE_WIDTH-1:0]                new_angle
);
   localparam int SW = ANGLE_WIDTH + 10;
   localparam int TW = ANGLE_WIDTH + 28;
   localparam int RW = TW - 24;
   localparam logic signed [RW-1:0] HI_LIM = RW'((longint'(1) <<< (ANGLE_WIDTH - 1)) - 1);
   localparam logic signed [RW-1:0] LO_LIM = -HI_LIM - RW'(1);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_MUL  = 3'd1;
   localparam logic [2:0] P_DIFF = 3'd2;
   localparam logic [2:0] P_MAC  = 3'd3;
   localparam logic [2:0] P_RND  = 3'd4;

   logic [2:0]  phase_ff;
   logic [3:0]  cnt_ff;
   logic        done_ff;

   logic signed [15:0]                      rate_ff;
   logic [15:0]                             ts_ff, alpha_ff;
   logic signed [ANGLE_WIDTH-1:0]           old_ff, res_ff;
   logic signed [cafilt_pkg::ACC_WIDTH-1:0] acc_ff;
   logic signed [32:0]                      mul_ff;
   logic signed [TW-1:0]                    diff_ff, total_ff;

   logic signed [32:0] mul_r;
   logic signed [SW-1:0] inc, sum, diff;
   logic signed [TW-1:0] tr;
   logic signed [RW-1:0] r;

   assign mul_r = mul_ff + 33'sd128;
   assign inc   = SW'(mul_r >>> 8);
   assign sum   = (SW'(old_ff) <<< 8) + inc;
   assign diff  = sum - (SW'(acc_ff) <<< 8);
   assign tr    = total_ff + TW'(longint'(1) <<< 23);
   assign r     = tr[TW-1:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            P_IDLE: if (start) phase_ff <= P_MUL;
            P_MUL:  phase_ff <= P_DIFF;
            P_DIFF: begin
               phase_ff <= P_MAC;
               cnt_ff   <= '0;
            end
            P_MAC: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd15) phase_ff <= P_RND;
            end
            P_RND: begin
               phase_ff <= P_IDLE;
               done_ff  <= 1'b1;
            end
            default: phase_ff <= P_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == P_IDLE && start) begin
         rate_ff  <= rate;
         ts_ff    <= time_step;
         alpha_ff <= blend_alpha;
         old_ff   <= old_angle;
         acc_ff   <= acc_angle;
      end
      if (phase_ff == P_MUL) begin
         mul_ff <= 33'(rate_ff) * 33'(signed'({1'b0, ts_ff}));
      end
      if (phase_ff == P_DIFF) begin
         diff_ff  <= TW'(diff);
         total_ff <= TW'(acc_ff) <<< 24;
      end
      if (phase_ff == P_MAC) begin
         if (alpha_ff[0]) total_ff <= total_ff + diff_ff;
         diff_ff  <= diff_ff <<< 1;
         alpha_ff <= {1'b0, alpha_ff[15:1]};
      end
      if (phase_ff == P_RND) begin
         if (r > HI_LIM)      res_ff <= ANGLE_WIDTH'(HI_LIM);
         else if (r < LO_LIM) res_ff <= ANGLE_WIDTH'(LO_LIM);
         else                 res_ff <= ANGLE_WIDTH'(r);
      end
   end

   assign done      = done_ff;
   assign new_angle = res_ff;

endmodule
`default_nettype wire

### rtl/core/complementary_attitude_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complementary_attitude_filter_core
// Pitch/roll complementary filter: accelerometer tilt by square root and
// CORDIC, blended with integrated gyro rates.
//
//   channel  direction  beat
//   req_     in         one IMU sample (gyro x/y, accel x/y/z)
//   rsp_     out        pitch and roll angle
//   APB      in/out     time_step at 0x0, blend_alpha at 0x4
//
// One sample runs the square root, the CORDIC iterations and the alpha
// multiply in series.
// Roll and pitch use their own units in parallel.
// Reset is synchronous; it clears the estimates and loads register defaults.
// A new sample is taken while the last result beat still stalls; the next
// result waits for the output register.
// ----------------------------------------------------------------------------
module complementary_attitude_filter_core #(
   parameter int CORDIC_ITERATIONS = cafilt_pkg::CORDIC_ITERATIONS,
   parameter int ANGLE_WIDTH       = cafilt_pkg::ANGLE_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire cafilt_pkg::req_data_type   req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output cafilt_pkg::rsp_data_type        rsp_data,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [2:0]                 paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_SQRT = 3'd2;
   localparam logic [2:0] ST_CORD = 3'd3;
   localparam logic [2:0] ST_BLND = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int RTW = cafilt_pkg::ROOT_WIDTH;
   localparam int ACW = cafilt_pkg::ACC_WIDTH;

   logic [2:0]                    state_ff;
   logic [15:0]                   time_step_ff, blend_alpha_ff;
   cafilt_pkg::req_data_type      req_ff;
   cafilt_pkg::rsp_data_type      rsp_data_ff;
   logic                          rsp_valid_ff;
   logic signed [ANGLE_WIDTH-1:0] pitch_est_ff, roll_est_ff;

   logic [cafilt_pkg::SQ_WIDTH-1:0] sq_roll, sq_pitch;
   logic                  sqrt_start, sqrt_roll_done, sqrt_pitch_done;
   logic [RTW-1:0]        root_roll, root_pitch;
   logic                  cord_roll_done, cord_pitch_done;
   logic signed [ACW-1:0] acc_roll, acc_pitch;
   logic                  blend_roll_done, blend_pitch_done;
   logic signed [ANGLE_WIDTH-1:0] roll_new, pitch_new;
   logic                  req_take, rsp_take, rsp_free, cfg_write;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   assign sqrt_start = state_ff == ST_LOAD;
   assign sq_roll  = 32'(32'(req_ff.accel_y) * 32'(req_ff.accel_y))
                   + 32'(32'(req_ff.accel_z) * 32'(req_ff.accel_z));
   assign sq_pitch = 32'(32'(req_ff.accel_x) * 32'(req_ff.accel_x))
                   + 32'(32'(req_ff.accel_z) * 32'(req_ff.accel_z));

   cafilt_isqrt u_sqrt_roll (
      .clock(clock), .reset(reset), .start(sqrt_start), .sq(sq_roll),
      .done(sqrt_roll_done), .root(root_roll)
   );
   cafilt_isqrt u_sqrt_pitch (
      .clock(clock), .reset(reset), .start(sqrt_start), .sq(sq_pitch),
      .done(sqrt_pitch_done), .root(root_pitch)
   );

   cafilt_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cord_roll (
      .clock(clock), .reset(reset), .start(sqrt_roll_done), .root(root_roll),
      .num(req_ff.accel_x), .done(cord_roll_done), .angle(acc_roll)
   );
   cafilt_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cord_pitch (
      .clock(clock), .reset(reset), .start(sqrt_pitch_done), .root(root_pitch),
      .num(req_ff.accel_y), .done(cord_pitch_done), .angle(acc_pitch)
   );

   cafilt_blend #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_blend_roll (
      .clock(clock), .reset(reset), .start(cord_roll_done),
      .old_angle(roll_est_ff), .rate(req_ff.gyro_rate_x), .acc_angle(acc_roll),
      .time_step(time_step_ff), .blend_alpha(blend_alpha_ff),
      .done(blend_roll_done), .new_angle(roll_new)
   );
   cafilt_blend #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_blend_pitch (
      .clock(clock), .reset(reset), .start(cord_pitch_done),
      .old_angle(pitch_est_ff), .rate(req_ff.gyro_rate_y), .acc_angle(acc_pitch),
      .time_step(time_step_ff), .blend_alpha(blend_alpha_ff),
      .done(blend_pitch_done), .new_angle(pitch_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pitch_est_ff   <= '0;
         roll_est_ff    <= '0;
         time_step_ff   <= cafilt_pkg::TIME_STEP_RESET;
         blend_alpha_ff <= cafilt_pkg::BLEND_ALPHA_RESET;
      end else begin
         if (cfg_write) begin
            case (paddr[2])
               cafilt_pkg::REG_TIME_STEP:   time_step_ff   <= pwdata[15:0];
               cafilt_pkg::REG_BLEND_ALPHA: blend_alpha_ff <= pwdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: if (req_take) state_ff <= ST_LOAD;
            ST_LOAD: state_ff <= ST_SQRT;
            ST_SQRT: if (sqrt_roll_done) state_ff <= ST_CORD;
            ST_CORD: if (cord_roll_done) state_ff <= ST_BLND;
            ST_BLND: if (blend_roll_done) state_ff <= ST_DONE;
            ST_DONE: begin
               if (rsp_free) begin
                  pitch_est_ff <= pitch_new;
                  roll_est_ff  <= roll_new;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_data;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff.pitch_angle <= 24'(32'(pitch_new));
         rsp_data_ff.roll_angle  <= 24'(32'(roll_new));
      end
   end

   always_comb begin
      case (paddr[2])
         cafilt_pkg::REG_TIME_STEP:   prdata = {16'h0000, time_step_ff};
         cafilt_pkg::REG_BLEND_ALPHA: prdata = {16'h0000, blend_alpha_ff};
         default:                     prdata = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_LOAD)
      else $error("accepted beat did not start the root");
   a_sqrt_lock: assert property (@(posedge clock) disable iff (reset)
      sqrt_roll_done == sqrt_pitch_done)
      else $error("square root units out of step");
   a_cord_lock: assert property (@(posedge clock) disable iff (reset)
      cord_roll_done == cord_pitch_done)
      else $error("cordic units out of step");
   a_blend_lock: assert property (@(posedge clock) disable iff (reset)
      blend_roll_done == blend_pitch_done)
      else $error("blend units out of step");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat without finished sample");
   a_blend_state: assert property (@(posedge clock) disable iff (reset)
      blend_roll_done |-> state_ff == ST_BLND)
      else $error("blend finished outside its phase");

endmodule
`default_nettype wire
